FILE: hdl/mandelbrot_escape_time_assert.svh
// Assertion macros shared by the escape-time block.
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define MBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must hold at the clock edge after its trigger.
`define MBE_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

FILE: hdl/mbe_pkg.sv
// Package with types and constants of the escape-time block.
package mbe_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 27;
  localparam int unsigned ITER_WIDTH_DEF  = 16;
  localparam int unsigned CFG_WIDTH       = 16;
  localparam int unsigned MAX_ITER_RESET  = 100;
  localparam int unsigned ESC_RADIUS_SQ   = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XX,
    ST_YY,
    ST_XY
  } state_e;

  typedef enum logic [1:0] {
    MUL_XX,
    MUL_YY,
    MUL_XY
  } mul_op_e;

  typedef struct packed {
    logic    init;
    logic    mul_en;
    mul_op_e op;
    logic    upd_y;
    logic    lat_x2;
    logic    upd_x;
  } ctrl_t;

endpackage

FILE: hdl/mbe_mul.sv
// Shared signed multiplier with operand select and registered product.
module mbe_mul #(
  parameter int unsigned W = 33
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic                    clr_i,
  input  mbe_pkg::mul_op_e        op_i,
  input  logic signed [W-1:0]     x_i,
  input  logic signed [W-1:0]     y_i,
  output logic signed [2*W-1:0]   prod_o
);

  logic signed [W-1:0]   a;
  logic signed [W-1:0]   b;
  logic signed [2*W-1:0] prod_d;
  logic signed [2*W-1:0] prod_q;

  always_comb begin
    unique case (op_i)
      mbe_pkg::MUL_XX: begin
        a = x_i;
        b = x_i;
      end
      mbe_pkg::MUL_YY: begin
        a = y_i;
        b = y_i;
      end
      mbe_pkg::MUL_XY: begin
        a = x_i;
        b = y_i;
      end
      default: begin
        a = x_i;
        b = y_i;
      end
    endcase
  end

  assign prod_d = a * b;

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      prod_q <= '0;
    end else if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: hdl/mbe_seq.sv
// Sequencer of the escape-time block: command handshake, limit register, counter.
`include "mandelbrot_escape_time_assert.svh"

module mbe_seq #(
  parameter int unsigned ITER_WIDTH = mbe_pkg::ITER_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mbe_pkg::CFG_WIDTH-1:0]  cfg_max_iterations_i,
  input  logic                           escape_i,
  output mbe_pkg::ctrl_t                 ctrl_o,
  output logic                           done_o,
  output logic [ITER_WIDTH-1:0]          iter_count_o
);

  mbe_pkg::state_e         state_q, state_d;
  logic [ITER_WIDTH-1:0]   cnt_q, cnt_d;
  logic [ITER_WIDTH-1:0]   lim_q, lim_d;
  logic [ITER_WIDTH-1:0]   res_q, res_d;
  logic [ITER_WIDTH-1:0]   cnt_inc;
  logic                    done_q, done_d;

  assign busy        = (state_q != mbe_pkg::ST_IDLE);
  assign cfg_ready_o = !busy && !start && !done_q;
  assign cnt_inc     = cnt_q + ITER_WIDTH'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbe_pkg::ST_IDLE;
      cnt_q   <= '0;
      lim_q   <= ITER_WIDTH'(mbe_pkg::MAX_ITER_RESET);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lim_q   <= lim_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    done_d  = 1'b0;
    ctrl_o  = '0;
    lim_d   = lim_q;
    if (cfg_valid_i && cfg_ready_o) begin
      lim_d = ITER_WIDTH'({{ITER_WIDTH{1'b0}}, cfg_max_iterations_i});
    end
    unique case (state_q)
      mbe_pkg::ST_IDLE: begin
        if (start) begin
          // The first iteration from z = 0 never escapes and yields z = c.
          ctrl_o.init = 1'b1;
          cnt_d       = ITER_WIDTH'(1);
          if (lim_q == '0) begin
            done_d = 1'b1;
            res_d  = '0;
          end else if (lim_q == ITER_WIDTH'(1)) begin
            done_d = 1'b1;
            res_d  = ITER_WIDTH'(1);
          end else begin
            state_d = mbe_pkg::ST_XX;
          end
        end
      end
      mbe_pkg::ST_XX: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op     = mbe_pkg::MUL_XX;
        ctrl_o.upd_y  = 1'b1;
        state_d       = mbe_pkg::ST_YY;
      end
      mbe_pkg::ST_YY: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op     = mbe_pkg::MUL_YY;
        ctrl_o.lat_x2 = 1'b1;
        state_d       = mbe_pkg::ST_XY;
      end
      mbe_pkg::ST_XY: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op     = mbe_pkg::MUL_XY;
        ctrl_o.upd_x  = 1'b1;
        if (escape_i) begin
          done_d  = 1'b1;
          res_d   = cnt_q;
          state_d = mbe_pkg::ST_IDLE;
        end else if (cnt_inc == lim_q) begin
          done_d  = 1'b1;
          res_d   = cnt_inc;
          state_d = mbe_pkg::ST_IDLE;
        end else begin
          cnt_d   = cnt_inc;
          state_d = mbe_pkg::ST_XX;
        end
      end
      default: begin
        state_d = mbe_pkg::ST_IDLE;
      end
    endcase
  end

  assign done_o       = done_q;
  assign iter_count_o = res_q;

  `MBE_ASSERT(a_done_when_idle, !done_q || (state_q == mbe_pkg::ST_IDLE), "result while busy")
  `MBE_ASSERT(a_res_in_limit, !done_q || (res_q <= lim_q), "result above limit")
  `MBE_ASSERT(a_cnt_in_range, !busy || ((cnt_q != '0) && (cnt_q < lim_q)), "count out of range")
  `MBE_ASSERT_NEXT(a_start_loop, start && !busy && (lim_q > ITER_WIDTH'(1)),
                   (state_q == mbe_pkg::ST_XX) && (cnt_q == ITER_WIDTH'(1)), "bad loop entry")

endmodule

FILE: hdl/mandelbrot_escape_time.sv
// Top level of the escape-time block: z registers, update adders and escape test.
// Usage:
// A point c is given on c_real_i and c_imag_i and taken at a clock edge with
// start high and busy low. The block then iterates z = z*z + c from z = 0
// while |z|^2 <= 4 and the count is below the limit register.
// One shared signed multiplier forms x*x, y*y and x*y in turn, so each
// iteration after the first steps through the states ST_XX, ST_YY and
// ST_XY; the first one needs no product. Busy stays high until the point
// stops at the limit or escapes. The result word is shown in the first
// cycle with busy low, and the next start can be taken in that same cycle.
// With a limit of 0 or 1 busy stays low, the result word follows the start
// edge directly and one point per cycle can be taken. The result is shown
// on iter_count_o for exactly one cycle with done_o high; the receiver
// cannot stall it.
// The limit is written through cfg_valid_i, cfg_ready_o and
// cfg_max_iterations_i; ready is high only while the block is idle, no start
// is offered and no result word is pending.
// Reset clears the sequencer state, count and done flag and sets the limit to 100.
module mandelbrot_escape_time #(
  parameter int unsigned COORD_WIDTH = mbe_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = mbe_pkg::FRAC_BITS_DEF,
  parameter int unsigned ITER_WIDTH  = mbe_pkg::ITER_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  c_real_i,
  input  logic signed [COORD_WIDTH-1:0]  c_imag_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mbe_pkg::CFG_WIDTH-1:0]  cfg_max_iterations_i,
  output logic                           done_o,
  output logic [ITER_WIDTH-1:0]          iter_count_o
);

  // While no escape has occurred |x| and |y| stay below |c| + 4.
  localparam int unsigned Z_W = (COORD_WIDTH + 1 > FRAC_BITS + 4) ? COORD_WIDTH + 1
                                                                  : FRAC_BITS + 4;
  localparam int unsigned P_W = 2 * Z_W;
  localparam logic [P_W-1:0] ESC_BOUND = P_W'(mbe_pkg::ESC_RADIUS_SQ) << FRAC_BITS;

  mbe_pkg::ctrl_t            ctrl;
  logic signed [COORD_WIDTH-1:0] cr_q;
  logic signed [COORD_WIDTH-1:0] ci_q;
  logic signed [Z_W-1:0]     x_q;
  logic signed [Z_W-1:0]     y_q;
  logic signed [P_W-1:0]     prod;
  logic signed [P_W-1:0]     sq_f;
  logic signed [P_W-1:0]     xy_f;
  logic signed [P_W-1:0]     x2_q;
  logic signed [P_W-1:0]     x_sum;
  logic signed [P_W-1:0]     y_sum;
  logic [P_W-1:0]            esc_sum;
  logic                      escape;

  mbe_seq #(
    .ITER_WIDTH (ITER_WIDTH)
  ) u_seq (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_max_iterations_i (cfg_max_iterations_i),
    .escape_i             (escape),
    .ctrl_o               (ctrl),
    .done_o               (done_o),
    .iter_count_o         (iter_count_o)
  );

  mbe_mul #(
    .W (Z_W)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .clr_i  (ctrl.init),
    .op_i   (ctrl.op),
    .x_i    (x_q),
    .y_i    (y_q),
    .prod_o (prod)
  );

  assign sq_f    = prod >>> FRAC_BITS;
  assign xy_f    = prod >>> (FRAC_BITS - 1);
  assign esc_sum = x2_q + sq_f;
  assign escape  = (esc_sum > ESC_BOUND);
  assign x_sum   = x2_q - sq_f + P_W'(cr_q);
  assign y_sum   = xy_f + P_W'(ci_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.init) begin
      cr_q <= c_real_i;
      ci_q <= c_imag_i;
      x_q  <= Z_W'(c_real_i);
    end else if (ctrl.upd_x) begin
      x_q  <= Z_W'(x_sum);
    end
    if (ctrl.upd_y) begin
      y_q <= Z_W'(y_sum);
    end
    if (ctrl.lat_x2) begin
      x2_q <= sq_f;
    end
  end

endmodule
